FILE: rtl/core/swcv_pkg.sv
// Shared constants and types for the sliding-window class vote block.
`default_nettype none

package swcv_pkg;

  // Fixed field widths
  localparam int ADDR_W  = 16;
  localparam int CLASS_W = 4;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 5;

  // APB register map
  localparam int APB_ADDR_W = 1;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_CLASS_COUNT = 1'b0;
  localparam logic [CFG_W-1:0] CLASS_COUNT_RESET = 5'd6;

  // Marks a count snapshot that is ready for the vote tree
  typedef struct packed {
    logic valid;
    logic rejected;
  } tok_t;

endpackage

`default_nettype wire

FILE: rtl/core/swcv_if.sv
// Event and result channel interfaces.
`default_nettype none

interface swcv_evt_if;
  logic                        valid;
  logic                        ready;
  logic [swcv_pkg::ADDR_W-1:0] event_address;

  modport source (output valid, output event_address, input ready);
  modport sink (input valid, input event_address, output ready);
endinterface

interface swcv_res_if;
  logic                         valid;
  logic                         ready;
  logic [swcv_pkg::CLASS_W-1:0] winner_class;
  logic [swcv_pkg::CNT_W-1:0]   winner_count;
  logic [swcv_pkg::CNT_W-1:0]   least_count;
  logic                         event_rejected;

  modport source (output valid, output winner_class, output winner_count,
                  output least_count, output event_rejected, input ready);
  modport sink (input valid, input winner_class, input winner_count,
                input least_count, input event_rejected, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sliding_window_class_vote.sv
// Top level of the sliding-window class vote block: APB register and channel wiring.
//
//   channel   dir   handshake      payload
//   evt       in    valid/ready    event_address[15:0]
//   res       out   valid/ready    winner_class[3:0], winner_count[7:0],
//                                  least_count[7:0], event_rejected
//   apb       in    psel/penable   class_count at address 0 (5 bits)
//
// In the back end an in-range event passes S_FETCH, which reads the evicted
// entry from the window memory, then S_UPDATE, which writes the new entry and
// updates counts; an out-of-range event passes S_FETCH only. Each event goes
// through the 2-entry queue, the back end, the vote tree and the output reg.
// Synchronous reset; the window needs no clearing pass. A stalled result
// stalls the vote tree and the back end; the queue takes events until full.
`default_nettype none

module sliding_window_class_vote #(
  parameter int WINDOW_DEPTH = 128,
  parameter int MAX_CLASSES  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swcv_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [swcv_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [swcv_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  swcv_evt_if.sink                            evt,
  swcv_res_if.source                          res
);

  localparam int EW   = $clog2(MAX_CLASSES);
  localparam int CW   = $clog2(WINDOW_DEPTH+1);
  localparam int NW   = $clog2(MAX_CLASSES+1);
  localparam int CMPW = (NW > swcv_pkg::CFG_W) ? NW : swcv_pkg::CFG_W;

  logic [swcv_pkg::CFG_W-1:0] class_count;
  logic [NW-1:0]              n_active;
  logic                       q_valid;
  logic [EW-1:0]              q_cls;
  logic                       q_rej;
  logic                       q_pop;
  logic                       adv;
  swcv_pkg::tok_t             tok;
  logic [CW-1:0]              counts [MAX_CLASSES];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= swcv_pkg::CLASS_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr == swcv_pkg::REG_CLASS_COUNT) begin
      class_count <= pwdata[swcv_pkg::CFG_W-1:0];
    end
  end

  assign prdata = (paddr == swcv_pkg::REG_CLASS_COUNT) ?
                  swcv_pkg::APB_DATA_W'(class_count) : '0;

  // saturate at the number of implemented classes
  assign n_active = (CMPW'(class_count) > CMPW'(MAX_CLASSES)) ?
                    NW'(MAX_CLASSES) : NW'(class_count);

  swcv_front #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .n_active (n_active),
    .evt      (evt),
    .q_valid  (q_valid),
    .q_cls    (q_cls),
    .q_rej    (q_rej),
    .q_pop    (q_pop)
  );

  swcv_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cls   (q_cls),
    .q_rej   (q_rej),
    .q_pop   (q_pop),
    .adv     (adv),
    .tok     (tok),
    .counts  (counts)
  );

  swcv_vote #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_vote (
    .clk      (clk),
    .rst      (rst),
    .n_active (n_active),
    .tok      (tok),
    .counts   (counts),
    .adv      (adv),
    .res      (res)
  );

endmodule

`default_nettype wire

FILE: rtl/core/swcv_front.sv
// Front end: accepts events, range-checks the address, queues them for the back end.
`default_nettype none

module swcv_front #(
  parameter int MAX_CLASSES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [$clog2(MAX_CLASSES+1)-1:0]    n_active,
  swcv_evt_if.sink                            evt,
  output logic                                q_valid,
  output logic [$clog2(MAX_CLASSES)-1:0]      q_cls,
  output logic                                q_rej,
  input  logic                                q_pop
);

  localparam int EW = $clog2(MAX_CLASSES);

  logic [EW-1:0] ent_cls [2];
  logic          ent_rej [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          rej_in;

  assign rej_in    = evt.event_address >= swcv_pkg::ADDR_W'(n_active);
  assign evt.ready = fill != 2'd2;
  assign push      = evt.valid && evt.ready;
  assign q_valid   = fill != 2'd0;
  assign q_cls     = ent_cls[rd_ptr];
  assign q_rej     = ent_rej[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_cls[wr_ptr] <= evt.event_address[EW-1:0];
      ent_rej[wr_ptr] <= rej_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/swcv_back.sv
// Back end: window memory, oldest pointer and per-class counts.
`default_nettype none

module swcv_back #(
  parameter int WINDOW_DEPTH = 128,
  parameter int MAX_CLASSES  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  logic [$clog2(MAX_CLASSES)-1:0]         q_cls,
  input  logic                                   q_rej,
  output logic                                   q_pop,
  input  logic                                   adv,
  output swcv_pkg::tok_t                         tok,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]      counts [MAX_CLASSES]
);

  localparam int EW = $clog2(MAX_CLASSES);
  localparam int CW = $clog2(WINDOW_DEPTH+1);
  localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  typedef enum logic {
    S_FETCH,
    S_UPDATE
  } state_t;

  state_t        state;
  logic [PW-1:0] ptr;
  logic          wrapped;
  logic [EW-1:0] cur_cls;
  logic [EW-1:0] rd_data;
  logic [EW-1:0] old_cls;
  logic          mem_re;
  logic          upd;
  logic [EW-1:0] mem [WINDOW_DEPTH];

  assign q_pop  = adv && q_valid && (state == S_FETCH);
  assign mem_re = q_pop && !q_rej;
  assign upd    = adv && (state == S_UPDATE);
  // entries not yet overwritten since reset are treated as class 0
  assign old_cls = wrapped ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FETCH;
      ptr     <= '0;
      wrapped <= 1'b0;
      tok     <= '0;
    end else if (adv) begin
      unique case (state)
        S_FETCH: begin
          if (q_valid && q_rej) begin
            tok <= '{valid: 1'b1, rejected: 1'b1};
          end else begin
            tok <= '0;
          end
          if (q_valid && !q_rej) begin
            cur_cls <= q_cls;
            state   <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          tok   <= '{valid: 1'b1, rejected: 1'b0};
          state <= S_FETCH;
          if (ptr == PW'(WINDOW_DEPTH - 1)) begin
            ptr     <= '0;
            wrapped <= 1'b1;
          end else begin
            ptr <= ptr + PW'(1);
          end
        end
        default: state <= S_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (upd) mem[ptr] <= cur_cls;
    if (mem_re) rd_data <= mem[ptr];
  end

  for (genvar i = 0; i < MAX_CLASSES; i++) begin : g_cnt
    logic          dec;
    logic          inc;
    logic [CW-1:0] cnt_next;

    assign dec      = (old_cls == EW'(i)) && (counts[i] != '0);
    assign inc      = cur_cls == EW'(i);
    assign cnt_next = counts[i] - CW'(dec) + CW'(inc);

    always_ff @(posedge clk) begin
      if (rst) begin
        counts[i] <= (i == 0) ? CW'(WINDOW_DEPTH) : '0;
      end else if (upd) begin
        counts[i] <= cnt_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/swcv_vote.sv
// Vote: registered max/min tree over the class counts and the result register.
`default_nettype none

module swcv_vote #(
  parameter int WINDOW_DEPTH = 128,
  parameter int MAX_CLASSES  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [$clog2(MAX_CLASSES+1)-1:0]    n_active,
  input  swcv_pkg::tok_t                      tok,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]   counts [MAX_CLASSES],
  output logic                                adv,
  swcv_res_if.source                          res
);

  localparam int LEVELS = $clog2(MAX_CLASSES);
  localparam int P      = 1 << LEVELS;
  localparam int CW     = $clog2(WINDOW_DEPTH+1);
  localparam int IW     = LEVELS;
  localparam int NW     = $clog2(MAX_CLASSES+1);

  typedef struct packed {
    logic          valid;
    logic [CW-1:0] max_cnt;
    logic [IW-1:0] max_idx;
    logic [CW-1:0] min_cnt;
  } node_t;

  // left child holds the lower indices, so ties keep the left winner
  function automatic node_t merge(node_t l, node_t r);
    node_t m;
    if (!r.valid) begin
      m = l;
    end else if (!l.valid) begin
      m = r;
    end else begin
      m.valid = 1'b1;
      if (r.max_cnt > l.max_cnt) begin
        m.max_cnt = r.max_cnt;
        m.max_idx = r.max_idx;
      end else begin
        m.max_cnt = l.max_cnt;
        m.max_idx = l.max_idx;
      end
      m.min_cnt = (r.min_cnt < l.min_cnt) ? r.min_cnt : l.min_cnt;
    end
    return m;
  endfunction

  node_t              leaf [P];
  node_t              node [1:P-1];
  swcv_pkg::tok_t     tok_pipe [LEVELS];
  node_t              root;
  logic [IW+3:0]      idx_ext;
  logic [CW+7:0]      win_ext;
  logic [CW+7:0]      min_ext;
  logic               out_valid;

  assign adv = !out_valid || res.ready;

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < MAX_CLASSES) begin : g_act
      assign leaf[i] = '{valid: (n_active > NW'(i)), max_cnt: counts[i],
                         max_idx: IW'(i), min_cnt: counts[i]};
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  for (genvar j = 1; j < P; j++) begin : g_node
    if (2 * j < P) begin : g_inner
      always_ff @(posedge clk) begin
        if (adv) node[j] <= merge(node[2*j], node[2*j+1]);
      end
    end else begin : g_bottom
      always_ff @(posedge clk) begin
        if (adv) node[j] <= merge(leaf[2*j-P], leaf[2*j+1-P]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LEVELS; k++) tok_pipe[k] <= '0;
    end else if (adv) begin
      tok_pipe[0] <= tok;
      for (int k = 1; k < LEVELS; k++) tok_pipe[k] <= tok_pipe[k-1];
    end
  end

  assign root    = node[1];
  assign idx_ext = {4'b0, root.max_idx};
  assign win_ext = {8'b0, root.max_cnt};
  assign min_ext = {8'b0, root.min_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tok_pipe[LEVELS-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_pipe[LEVELS-1].valid) begin
      res.event_rejected <= tok_pipe[LEVELS-1].rejected;
      // no active classes: vote fields all zero
      res.winner_class   <= root.valid ? idx_ext[3:0] : '0;
      res.winner_count   <= root.valid ? win_ext[7:0] : '0;
      res.least_count    <= root.valid ? min_ext[7:0] : '0;
    end
  end

  assign res.valid = out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/swcv_checker.sv
// Port-level checks for the sliding-window class vote block, with bind.
`default_nettype none

module swcv_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         evt_valid,
  input logic                         evt_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [swcv_pkg::CLASS_W-1:0] winner_class,
  input logic [swcv_pkg::CNT_W-1:0]   winner_count,
  input logic [swcv_pkg::CNT_W-1:0]   least_count,
  input logic                         event_rejected
);

  logic [7:0] pending;
  logic       evt_take;
  logic       res_take;

  assign evt_take = evt_valid && evt_ready;
  assign res_take = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(evt_take) - 8'(res_take);
    end
  end

  // every result belongs to an accepted event not yet answered
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 8'd0)
    else $error("result without an outstanding event");

  a_vote_order: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> least_count <= winner_count)
    else $error("least count above winner count");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(winner_class) &&
      $stable(winner_count) && $stable(least_count) && $stable(event_rejected))
    else $error("stalled result changed");

endmodule

bind sliding_window_class_vote swcv_checker u_swcv_checker (
  .clk            (clk),
  .rst            (rst),
  .evt_valid      (evt.valid),
  .evt_ready      (evt.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .winner_class   (res.winner_class),
  .winner_count   (res.winner_count),
  .least_count    (res.least_count),
  .event_rejected (res.event_rejected)
);

`default_nettype wire

FILE: tb/sliding_window_class_vote_tb.sv
// Self-checking testbench for the sliding-window class vote block.
`timescale 1ns / 1ps

module sliding_window_class_vote_tb;

  localparam int WINDOW_DEPTH    = 128;
  localparam int MAX_CLASSES     = 16;
  localparam int SETTLE_CYCLES   = 10;   // a bit over the pipeline latency
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT      = 4000;

  typedef struct packed {
    logic [swcv_pkg::CLASS_W-1:0] winner_class;
    logic [swcv_pkg::CNT_W-1:0]   winner_count;
    logic [swcv_pkg::CNT_W-1:0]   least_count;
    logic                         event_rejected;
  } vote_t;

  typedef struct {
    bit                          is_cfg;
    logic [swcv_pkg::ADDR_W-1:0] value;  // event address, or class count for a config row
    bit                          typed;  // expected vote written into the row
    vote_t                       vote;
  } dir_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [swcv_pkg::APB_ADDR_W-1:0] paddr;
  logic [swcv_pkg::APB_DATA_W-1:0] pwdata;
  logic [swcv_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  swcv_evt_if evt_ch ();
  swcv_res_if res_ch ();

  sliding_window_class_vote #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .MAX_CLASSES (MAX_CLASSES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .evt    (evt_ch),
    .res    (res_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predictor state
  logic [swcv_pkg::CLASS_W-1:0] win_store [WINDOW_DEPTH];
  int unsigned                  oldest_idx;
  int unsigned                  class_tally [MAX_CLASSES];
  logic [swcv_pkg::CFG_W-1:0]   class_cfg;

  vote_t    pending_votes [$];
  dir_row_t dir_script [$];

  int  fail_count;
  int  events_sent;
  int  results_checked;
  int  rejected_seen;
  int  settings_used;
  int  burst_left;
  bit  no_gaps;
  bit  hold_off_req;
  int  idle_cycles;

  function automatic void reset_predictor();
    for (int i = 0; i < WINDOW_DEPTH; i++) win_store[i] = '0;
    for (int i = 0; i < MAX_CLASSES; i++) class_tally[i] = 0;
    class_tally[0] = WINDOW_DEPTH;
    oldest_idx = 0;
    class_cfg = swcv_pkg::CLASS_COUNT_RESET;
  endfunction

  function automatic int unsigned active_classes(input logic [swcv_pkg::CFG_W-1:0] cfg);
    return (32'(cfg) > 32'(MAX_CLASSES)) ? 32'(MAX_CLASSES) : 32'(cfg);
  endfunction

  // Window update and vote, from the state after the update
  function automatic vote_t vote_predict(input logic [swcv_pkg::ADDR_W-1:0] a);
    int unsigned n;
    int unsigned victim;
    int unsigned best;
    int unsigned least;
    vote_t r;
    n = active_classes(class_cfg);
    r = '0;
    if (32'(a) < n) begin
      victim = 32'(win_store[oldest_idx]);
      if (class_tally[victim] > 0) class_tally[victim]--;
      win_store[oldest_idx] = a[swcv_pkg::CLASS_W-1:0];
      class_tally[a[swcv_pkg::CLASS_W-1:0]]++;
      oldest_idx = (oldest_idx + 1) % WINDOW_DEPTH;
    end else begin
      r.event_rejected = 1'b1;
    end
    if (n > 0) begin
      best = class_tally[0];
      least = class_tally[0];
      for (int i = 1; i < n; i++) begin
        if (class_tally[i] > best) begin
          best = class_tally[i];
          r.winner_class = i[swcv_pkg::CLASS_W-1:0];
        end
        if (class_tally[i] < least) least = class_tally[i];
      end
      r.winner_count = best[swcv_pkg::CNT_W-1:0];
      r.least_count = least[swcv_pkg::CNT_W-1:0];
    end
    return r;
  endfunction

  function automatic dir_row_t row_event(input logic [swcv_pkg::ADDR_W-1:0] a);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.value = a;
    r.typed = 1'b0;
    r.vote = '0;
    return r;
  endfunction

  function automatic dir_row_t row_checked(input logic [swcv_pkg::ADDR_W-1:0] a,
                                           input int unsigned wc,
                                           input int unsigned cnt, input int unsigned least,
                                           input bit rej);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.value = a;
    r.typed = 1'b1;
    r.vote.winner_class = wc[swcv_pkg::CLASS_W-1:0];
    r.vote.winner_count = cnt[swcv_pkg::CNT_W-1:0];
    r.vote.least_count = least[swcv_pkg::CNT_W-1:0];
    r.vote.event_rejected = rej;
    return r;
  endfunction

  function automatic dir_row_t row_config(input int unsigned v);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.value = v[swcv_pkg::ADDR_W-1:0];
    r.typed = 1'b0;
    r.vote = '0;
    return r;
  endfunction

  function automatic void add_row(input dir_row_t r);
    dir_script = {dir_script, r};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Offer one event and hold it until the transaction completes
  task automatic send_event(input logic [swcv_pkg::ADDR_W-1:0] a, input bit typed,
                            input vote_t typed_vote);
    vote_t predicted;
    evt_ch.valid <= 1'b1;
    evt_ch.event_address <= a;
    do @(posedge clk); while (!evt_ch.ready);
    predicted = vote_predict(a);
    pending_votes = {pending_votes, (typed ? typed_vote : predicted)};
    events_sent++;
  endtask

  // Burst/gap pacing on the event side
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      if (!no_gaps) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
        evt_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    evt_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_votes.size() != 0);
  endtask

  // Write class_count, then read it back
  task automatic set_class_count(input int unsigned v);
    logic [swcv_pkg::APB_DATA_W-1:0] word;
    repeat (SETTLE_CYCLES) @(posedge clk);
    word = $urandom;
    word[swcv_pkg::CFG_W-1:0] = v[swcv_pkg::CFG_W-1:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= swcv_pkg::REG_CLASS_COUNT;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    class_cfg = v[swcv_pkg::CFG_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("class_count readback", 32'(class_cfg), 32'(prdata[swcv_pkg::CFG_W-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // Mostly valid addresses with a drifting favorite, plus near misses and raw noise
  function automatic logic [swcv_pkg::ADDR_W-1:0] pick_address(input int unsigned n,
                                                               input int unsigned favored);
    int unsigned r;
    logic [31:0] raw;
    r = $urandom_range(0, 99);
    if (r < 70 && n > 0) begin
      if ($urandom_range(0, 99) < 60) raw = favored;
      else raw = $urandom_range(0, n - 1);
    end else if (r < 85) begin
      raw = $urandom_range(0, 31);
    end else begin
      raw = $urandom;
    end
    return raw[swcv_pkg::ADDR_W-1:0];
  endfunction

  // Result side: checks each accepted vote against the oldest expectation
  always @(posedge clk) begin : vote_check
    vote_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_votes.size() == 0) begin
        $error("result with no event pending: class %0d count %0d",
               res_ch.winner_class, res_ch.winner_count);
        fail_count++;
      end else begin
        want = pending_votes[0];
        pending_votes.delete(0);
        check_field("winner_class", 32'(want.winner_class), 32'(res_ch.winner_class));
        check_field("winner_count", 32'(want.winner_count), 32'(res_ch.winner_count));
        check_field("least_count", 32'(want.least_count), 32'(res_ch.least_count));
        check_field("event_rejected", 32'(want.event_rejected),
                    32'(res_ch.event_rejected));
        results_checked++;
        if (res_ch.event_rejected) rejected_seen++;
      end
    end
  end

  // Result side stall pattern, with one long hold-off on request
  initial begin : sink_pattern
    int span;
    int style;
    res_ch.ready = 1'b0;
    span = 0;
    style = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span = $urandom_range(5, 60);
      end
      span--;
      case (style)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 1) == 1);
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= (span % 4 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results pending",
               IDLE_LIMIT, pending_votes.size());
      $display("** sliding_window_class_vote: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned cfg_plan [$];
    int unsigned cfg_val;
    int unsigned n;
    int unsigned favored;
    int unsigned phase_len;
    dir_row_t row;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    evt_ch.valid = 1'b0;
    evt_ch.event_address = '0;
    fail_count = 0;
    events_sent = 0;
    results_checked = 0;
    rejected_seen = 0;
    settings_used = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_off_req = 1'b0;
    idle_cycles = 0;
    reset_predictor();

    // After reset the window is all class 0 and the count is 6
    add_row(row_checked(16'd0, 0, 128, 0, 1'b0));
    add_row(row_checked(16'hFFFF, 0, 128, 0, 1'b1));
    add_row(row_checked(16'd6, 0, 128, 0, 1'b1));
    add_row(row_checked(16'd5, 0, 127, 0, 1'b0));
    add_row(row_event(16'd1));
    add_row(row_event(16'h8000));
    add_row(row_event(16'd4));
    add_row(row_event(16'd3));
    // no active classes: everything rejected, vote fields zero
    add_row(row_config(0));
    add_row(row_checked(16'd0, 0, 0, 0, 1'b1));
    add_row(row_checked(16'hFFFF, 0, 0, 0, 1'b1));
    // count above the class limit saturates
    add_row(row_config(31));
    add_row(row_event(16'd15));
    add_row(row_event(16'd16));
    add_row(row_event(16'd30));
    add_row(row_event(16'd14));
    add_row(row_config(16));
    add_row(row_event(16'd15));
    add_row(row_event(16'h7FFF));
    // lowered count: high classes stay in the window but drop out of the vote
    add_row(row_config(1));
    add_row(row_event(16'd0));
    add_row(row_event(16'd1));
    add_row(row_event(16'd15));
    add_row(row_config(2));
    add_row(row_event(16'd1));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_script[i]) begin
      row = dir_script[i];
      if (row.is_cfg) begin
        drain_results();
        set_class_count(32'(row.value));
      end else begin
        send_event(row.value, row.typed, row.vote);
        pace();
      end
    end

    cfg_plan = '{16, 31, 1, 0, 3, 17, 8, 2, 15, 6};
    cfg_plan = {cfg_plan, $urandom_range(0, 31)};

    foreach (cfg_plan[k]) begin
      drain_results();
      cfg_val = cfg_plan[k];
      set_class_count(cfg_val);
      n = active_classes(cfg_val[swcv_pkg::CFG_W-1:0]);
      phase_len = (n == 0) ? 30 : 130;
      favored = 0;
      if (k == 1) begin
        // back-pressure: sink holds off while events keep coming
        no_gaps = 1'b1;
        hold_off_req = 1'b1;
      end
      for (int j = 0; j < phase_len; j++) begin
        if (j % 40 == 0 && n > 0) favored = $urandom_range(0, n - 1);
        if (k == 4 && j == 60) drain_results();
        send_event(pick_address(n, favored), 1'b0, '0);
        pace();
        if (k == 1 && j == 60) no_gaps = 1'b0;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES * 3) @(posedge clk);
    if (pending_votes.size() != 0) begin
      $error("%0d expected results never arrived", pending_votes.size());
      fail_count++;
    end

    $display("Sent %0d events over %0d class-count settings (0, 1, 16 and saturating 31 incl.)",
             events_sent, settings_used);
    $display("Checked %0d votes, %0d of them rejected events; %0d mismatches",
             results_checked, rejected_seen, fail_count);
    if (fail_count == 0) begin
      $display("** sliding_window_class_vote: PASSED **");
    end else begin
      $display("** sliding_window_class_vote: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sliding_window_class_vote.f
rtl/core/swcv_pkg.sv
rtl/core/swcv_if.sv
rtl/core/swcv_front.sv
rtl/core/swcv_back.sv
rtl/core/swcv_vote.sv
rtl/core/sliding_window_class_vote.sv
rtl/core/swcv_checker.sv
tb/sliding_window_class_vote_tb.sv
